[design/fskm_pkg.sv]
// Shared constants, operation codes and the result flag bundle for the FSK frame modulator.
// No dependencies; used by every module of the block.
package fskm_pkg;

    // Default geometry
    localparam int SAMPLES_PER_BIT = 83;
    localparam int DAC_BITS        = 12;

    // Frame layout: start, eight data bits LSB first, odd parity, stop
    localparam int FRAME_BITS = 11;
    localparam int CHAR_W     = 8;
    localparam int BIT_POS_W  = 4;
    localparam int CODE_W     = 12;

    // Operation codes of an input beat
    typedef enum logic {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } op_t;

    // Flags of one result beat, produced by the frame controller
    typedef struct packed {
        logic sample_valid;
        logic load_accepted;
        logic frame_done;
        logic busy_res;
    } res_flags_t;

endpackage

[design/fskm_wave_rom.sv]
// Synchronous sine ROM: one period of the tone, WAVE_PERIOD entries, read data registered.
// Contents are built at elaboration from the Q30 series below. Depends on fskm_pkg.
module fskm_wave_rom #(
    parameter int SAMPLES_PER_BIT = fskm_pkg::SAMPLES_PER_BIT,
    parameter int DAC_BITS        = fskm_pkg::DAC_BITS,
    localparam int WAVE_PERIOD    = SAMPLES_PER_BIT - 1,
    localparam int IDX_W          = $clog2(WAVE_PERIOD)
) (
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [IDX_W-1:0]             rd_addr,
    output logic [fskm_pkg::CODE_W-1:0]  rd_data
);

    localparam logic [63:0] Q_ONE   = 64'd1 << 30;
    localparam logic [63:0] PI_Q32  = 64'd13493037705;
    localparam logic [63:0] M_Q     = 64'(WAVE_PERIOD);
    localparam logic [63:0] THETA_D = 64'(8 * WAVE_PERIOD);
    localparam logic [63:0] FULL    = (64'd1 << DAC_BITS) - 64'd1;

    typedef logic [fskm_pkg::CODE_W-1:0] wave_rom_t [WAVE_PERIOD];

    // One minus an already scaled term, clamped at zero
    function automatic logic [63:0] sat_one_minus(input logic [63:0] p);
        return (p >= Q_ONE) ? 64'd0 : (Q_ONE - p);
    endfunction

    function automatic logic [63:0] sin_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        x2 = (x * x) >> 30;
        t  = Q_ONE;
        t  = sat_one_minus(((x2 * t) >> 30) / 156);
        t  = sat_one_minus(((x2 * t) >> 30) / 110);
        t  = sat_one_minus(((x2 * t) >> 30) / 72);
        t  = sat_one_minus(((x2 * t) >> 30) / 42);
        t  = sat_one_minus(((x2 * t) >> 30) / 20);
        t  = sat_one_minus(((x2 * t) >> 30) / 6);
        return (x * t) >> 30;
    endfunction

    function automatic logic [63:0] cos_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        x2 = (x * x) >> 30;
        t  = Q_ONE;
        t  = sat_one_minus(((x2 * t) >> 30) / 132);
        t  = sat_one_minus(((x2 * t) >> 30) / 90);
        t  = sat_one_minus(((x2 * t) >> 30) / 56);
        t  = sat_one_minus(((x2 * t) >> 30) / 30);
        t  = sat_one_minus(((x2 * t) >> 30) / 12);
        t  = sat_one_minus(((x2 * t) >> 30) / 2);
        return t;
    endfunction

    // DAC code for phase step k of one period
    function automatic logic [fskm_pkg::CODE_W-1:0] wave_code(input logic [63:0] k);
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] theta;
        logic [63:0] mag;
        logic [63:0] base;
        logic [63:0] code;
        q     = (64'd4 * k) / M_Q;
        rem   = 64'd4 * k - q * M_Q;
        theta = (PI_Q32 * rem + 64'd4 * M_Q) / THETA_D;
        mag   = q[0] ? cos_q30(theta) : sin_q30(theta);
        if (mag > Q_ONE)
        begin
            mag = Q_ONE;
        end
        base  = (q >= 64'd2) ? (Q_ONE - mag) : (Q_ONE + mag);
        code  = ((base * FULL) + Q_ONE) >> 31;
        return code[fskm_pkg::CODE_W-1:0];
    endfunction

    function automatic wave_rom_t build_rom();
        wave_rom_t rom;
        for (int i = 0; i < WAVE_PERIOD; i++)
        begin
            rom[i] = wave_code(64'(i));
        end
        return rom;
    endfunction

    localparam wave_rom_t WAVE_ROM = build_rom();

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= WAVE_ROM[rd_addr];
        end
    end

endmodule

[design/fskm_frame_ctrl.sv]
// Frame controller: frame register, bit and sample counters, tone select and ROM addressing.
// Updates on every accepted beat. Depends on fskm_pkg.
module fskm_frame_ctrl #(
    parameter int SAMPLES_PER_BIT = fskm_pkg::SAMPLES_PER_BIT,
    localparam int WAVE_PERIOD    = SAMPLES_PER_BIT - 1,
    localparam int SP_W           = $clog2(SAMPLES_PER_BIT),
    localparam int IDX_W          = $clog2(WAVE_PERIOD)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          operation,
    input  logic [fskm_pkg::CHAR_W-1:0]   character,
    output logic [IDX_W-1:0]              wave_addr,
    output fskm_pkg::res_flags_t          flags
);

    localparam logic [SP_W-1:0]  SP_LAST  = SP_W'(WAVE_PERIOD);
    localparam logic [SP_W:0]    SP2_WRAP = (SP_W + 1)'(WAVE_PERIOD);
    localparam logic [fskm_pkg::BIT_POS_W-1:0] BIT_LAST =
        fskm_pkg::BIT_POS_W'(fskm_pkg::FRAME_BITS - 1);

    logic [fskm_pkg::FRAME_BITS-1:0] frame_bits_reg, frame_bits_next;
    logic [fskm_pkg::BIT_POS_W-1:0]  bit_pos_reg, bit_pos_next;
    logic [SP_W-1:0]                 sample_pos_reg, sample_pos_next;
    logic                            sending_reg, sending_next;
    logic                            pending_reg, pending_next;
    logic                            space_reg, space_next;

    logic                            is_load;
    logic                            at_bound;
    logic                            start;
    logic                            sending_now;
    logic                            pending_now;
    logic [fskm_pkg::BIT_POS_W-1:0]  bit_pos_now;
    logic [15:0]                     frame_ext;
    logic                            space_now;
    logic                            last_sample;
    logic [SP_W:0]                   sp_twice;
    logic [SP_W:0]                   space_idx;

    assign is_load = (operation == fskm_pkg::OP_LOAD);

    // Frame starts on a tick at a bit boundary
    assign at_bound    = (sample_pos_reg == '0);
    assign start       = !is_load && at_bound && !sending_reg && pending_reg;
    assign sending_now = sending_reg || start;
    assign pending_now = pending_reg && !start;
    assign bit_pos_now = start ? '0 : bit_pos_reg;

    // Bits past the stop bit read as mark
    assign frame_ext = {{(16 - fskm_pkg::FRAME_BITS){1'b1}}, frame_bits_reg};
    assign space_now = at_bound ? (sending_now && !frame_ext[bit_pos_now]) : space_reg;

    assign last_sample = (sample_pos_reg == SP_LAST);

    // Table address: one period per bit for mark, two for space
    assign sp_twice  = {sample_pos_reg, 1'b0};
    assign space_idx = (sp_twice >= SP2_WRAP) ? (sp_twice - SP2_WRAP) : sp_twice;

    always_comb
    begin
        if (last_sample)
        begin
            wave_addr = '0;
        end
        else if (space_now)
        begin
            wave_addr = space_idx[IDX_W-1:0];
        end
        else
        begin
            wave_addr = sample_pos_reg[IDX_W-1:0];
        end
    end

    // Next state and result flags
    always_comb
    begin
        frame_bits_next = frame_bits_reg;
        bit_pos_next    = bit_pos_reg;
        sample_pos_next = sample_pos_reg;
        sending_next    = sending_reg;
        pending_next    = pending_reg;
        space_next      = space_reg;
        flags           = '0;
        if (is_load)
        begin
            if (!pending_reg && !sending_reg)
            begin
                frame_bits_next     = {1'b1, ~^character, character, 1'b0};
                pending_next        = 1'b1;
                flags.load_accepted = 1'b1;
            end
            flags.busy_res = 1'b1;
        end
        else
        begin
            flags.sample_valid = 1'b1;
            pending_next       = pending_now;
            sending_next       = sending_now;
            bit_pos_next       = bit_pos_now;
            space_next         = space_now;
            sample_pos_next    = last_sample ? '0 : (sample_pos_reg + 1'b1);
            if (last_sample && sending_now)
            begin
                if (bit_pos_now >= BIT_LAST)
                begin
                    flags.frame_done = 1'b1;
                    sending_next     = 1'b0;
                    bit_pos_next     = '0;
                end
                else
                begin
                    bit_pos_next = bit_pos_now + 1'b1;
                end
            end
            flags.busy_res = pending_next || sending_next;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_bits_reg <= '1;
            bit_pos_reg    <= '0;
            sample_pos_reg <= '0;
            sending_reg    <= 1'b0;
            pending_reg    <= 1'b0;
            space_reg      <= 1'b0;
        end
        else if (accept)
        begin
            frame_bits_reg <= frame_bits_next;
            bit_pos_reg    <= bit_pos_next;
            sample_pos_reg <= sample_pos_next;
            sending_reg    <= sending_next;
            pending_reg    <= pending_next;
            space_reg      <= space_next;
        end
    end

endmodule

[design/fsk_frame_modulator_top.sv]
// Top level of the FSK frame modulator: handshake, output register, controller and sine ROM.
// Depends on fskm_pkg, fskm_frame_ctrl and fskm_wave_rom.
//
//  beat       | valid     | stall     | payload
//  -----------+-----------+-----------+------------------------------------------------
//  input      | in_valid  | in_stall  | operation, character
//  result     | out_valid | out_stall | sample_valid, dac_code, load_accepted,
//             |           |           | frame_done, busy_res
//
// One beat per cycle while no result is held; each result appears in the cycle after its
// input beat is accepted; the sine ROM's registered read doubles as the output register.
// rst_n clears counters and flags at once; the ROM needs no clearing.
// A held result (out_valid with out_stall) raises in_stall in the same cycle; no beat
// is lost or taken twice.
module fsk_frame_modulator_top #(
    parameter int SAMPLES_PER_BIT = fskm_pkg::SAMPLES_PER_BIT,
    parameter int DAC_BITS        = fskm_pkg::DAC_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         operation,
    input  logic [fskm_pkg::CHAR_W-1:0]  character,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         sample_valid,
    output logic [fskm_pkg::CODE_W-1:0]  dac_code,
    output logic                         load_accepted,
    output logic                         frame_done,
    output logic                         busy_res
);

    localparam int IDX_W = $clog2(SAMPLES_PER_BIT - 1);

    logic                         accept;
    logic                         advance;
    logic [IDX_W-1:0]             wave_addr;
    logic [fskm_pkg::CODE_W-1:0]  wave_data;
    fskm_pkg::res_flags_t         flags;
    fskm_pkg::res_flags_t         flags_reg;
    logic                         out_valid_reg;

    // Handshake
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = !advance;
    assign accept   = in_valid && advance;

    fskm_frame_ctrl #(
        .SAMPLES_PER_BIT (SAMPLES_PER_BIT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .operation (operation),
        .character (character),
        .wave_addr (wave_addr),
        .flags     (flags)
    );

    fskm_wave_rom #(
        .SAMPLES_PER_BIT (SAMPLES_PER_BIT),
        .DAC_BITS        (DAC_BITS)
    ) u_rom (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (wave_addr),
        .rd_data (wave_data)
    );

    // Output register alongside the ROM read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid;
            if (in_valid)
            begin
                flags_reg <= flags;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign sample_valid  = flags_reg.sample_valid;
    assign dac_code      = flags_reg.sample_valid ? wave_data : '0;
    assign load_accepted = flags_reg.load_accepted;
    assign frame_done    = flags_reg.frame_done;
    assign busy_res      = flags_reg.busy_res;

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for fsk_frame_modulator_top: drives tick and load beats,
// predicts every result beat (frame state plus fixed-point sine) and checks it field by field.
// Depends on fskm_pkg and the RTL of the block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fskm_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 8;
    localparam bit [63:0] Q30_ONE = 64'd1 << 30;
    localparam bit [63:0] PI_Q32 = 64'd13493037705;

    // One expected result beat
    typedef struct packed {
        logic              sample_valid;
        logic [CODE_W-1:0] dac_code;
        logic              load_accepted;
        logic              frame_done;
        logic              busy_res;
    } fsk_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              operation = OP_TICK;
    logic [CHAR_W-1:0] character = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              sample_valid;
    logic [CODE_W-1:0] dac_code;
    logic              load_accepted;
    logic              frame_done;
    logic              busy_res;

    // Predicted modulator state
    logic [FRAME_BITS-1:0] pend_frame;
    int unsigned           frame_bit;
    int unsigned           sample_idx;
    bit                    sending;
    bit                    pending;
    bit                    space_tone;

    fsk_result_t expected_q[$];
    int unsigned mismatch_count = 0;
    int unsigned beats_sent = 0;
    int unsigned loads_taken = 0;
    int unsigned frames_sent = 0;
    int unsigned results_checked = 0;
    int unsigned burst_left = 0;
    int unsigned quiet_cycles = 0;
    int unsigned stall_phase = 0;

    fsk_frame_modulator_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .character     (character),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample_valid  (sample_valid),
        .dac_code      (dac_code),
        .load_accepted (load_accepted),
        .frame_done    (frame_done),
        .busy_res      (busy_res)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Q30: 1 - a*t/den, truncated and clamped at zero
    function automatic bit [63:0] q30_one_minus(input bit [63:0] a, input bit [63:0] t,
                                                input bit [63:0] den);
        bit [63:0] p;
        p = ((a * t) >> 30) / den;
        return (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
    endfunction

    // Taylor sine to x^13, nested form
    function automatic bit [63:0] q30_sine(input bit [63:0] x);
        bit [63:0] x2, t;
        x2 = (x * x) >> 30;
        t = q30_one_minus(x2, Q30_ONE, 156);
        t = q30_one_minus(x2, t, 110);
        t = q30_one_minus(x2, t, 72);
        t = q30_one_minus(x2, t, 42);
        t = q30_one_minus(x2, t, 20);
        t = q30_one_minus(x2, t, 6);
        return (x * t) >> 30;
    endfunction

    // Taylor cosine to x^12
    function automatic bit [63:0] q30_cosine(input bit [63:0] x);
        bit [63:0] x2, t;
        x2 = (x * x) >> 30;
        t = q30_one_minus(x2, Q30_ONE, 132);
        t = q30_one_minus(x2, t, 90);
        t = q30_one_minus(x2, t, 56);
        t = q30_one_minus(x2, t, 30);
        t = q30_one_minus(x2, t, 12);
        return q30_one_minus(x2, t, 2);
    endfunction

    // DAC code of one sample; the last index of a bit folds back to angle zero
    function automatic logic [CODE_W-1:0] tone_code(input int unsigned idx, input bit space);
        bit [63:0] span, k, quad, rem, theta, mag, base, full;
        span = 64'(SAMPLES_PER_BIT - 1);
        k = (64'(idx) * (space ? 64'd2 : 64'd1)) % span;
        quad = (64'd4 * k) / span;
        rem = 64'd4 * k - quad * span;
        theta = (PI_Q32 * rem + 64'd4 * span) / (64'd8 * span);
        mag = quad[0] ? q30_cosine(theta) : q30_sine(theta);
        if (mag > Q30_ONE)
            mag = Q30_ONE;
        base = (quad >= 64'd2) ? Q30_ONE - mag : Q30_ONE + mag;
        full = (64'd1 << DAC_BITS) - 64'd1;
        return CODE_W'((base * full + Q30_ONE) >> 31);
    endfunction

    function automatic void reset_modulator_state();
        pend_frame = '1;
        frame_bit = 0;
        sample_idx = 0;
        sending = 1'b0;
        pending = 1'b0;
        space_tone = 1'b0;
    endfunction

    // Advance the predicted state by one accepted beat and return its result
    function automatic fsk_result_t modulate_beat(input op_t op, input logic [CHAR_W-1:0] ch);
        fsk_result_t r;
        r = '0;
        if (op == OP_LOAD)
        begin
            if (!pending && !sending)
            begin
                // stop, odd parity, data LSB first, start
                pend_frame = {1'b1, ~^ch, ch, 1'b0};
                pending = 1'b1;
                r.load_accepted = 1'b1;
                loads_taken++;
            end
        end
        else
        begin
            r.sample_valid = 1'b1;
            // tone is chosen only at a bit boundary; a pending frame starts here
            if (sample_idx == 0)
            begin
                if (!sending && pending)
                begin
                    sending = 1'b1;
                    pending = 1'b0;
                    frame_bit = 0;
                end
                space_tone = sending ? !pend_frame[frame_bit] : 1'b0;
            end
            r.dac_code = tone_code(sample_idx, space_tone);
            sample_idx++;
            if (sample_idx >= SAMPLES_PER_BIT)
            begin
                sample_idx = 0;
                if (sending)
                begin
                    if (frame_bit >= FRAME_BITS - 1)
                    begin
                        r.frame_done = 1'b1;
                        sending = 1'b0;
                        frame_bit = 0;
                        frames_sent++;
                    end
                    else
                    begin
                        frame_bit++;
                    end
                end
            end
        end
        r.busy_res = pending | sending;
        return r;
    endfunction

    // Send one beat: bursts with random gaps, hold payload until accepted
    task automatic send_beat(input op_t op, input logic [CHAR_W-1:0] ch);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
        end
        burst_left--;
        in_valid <= 1'b1;
        operation <= op;
        character <= ch;
        do
            @(posedge clk);
        while (in_stall);
        expected_q.push_back(modulate_beat(op, ch));
        beats_sent++;
    endtask

    // Hold off the sender until every expected result has come back
    task automatic wait_results_drained();
        if (in_valid)
            in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    // Load at a boundary from idle, busy rejections while pending and sending
    task automatic test_directed();
        send_beat(OP_LOAD, 8'hFF);
        send_beat(OP_LOAD, 8'h00);
        send_beat(OP_TICK, 8'hFF);
        send_beat(OP_LOAD, 8'hA5);
        send_beat(OP_TICK, 8'h00);
        send_beat(OP_TICK, 8'h5A);
        send_beat(OP_LOAD, 8'h00);
        send_beat(OP_TICK, 8'hFF);
    endtask

    // One whole frame: random lead-in of idle mark tone so the load usually lands
    // mid-bit, then ticks until the stop bit ends, with stray loads that must be refused
    task automatic play_frame(input logic [CHAR_W-1:0] ch);
        int unsigned lead;
        lead = $urandom_range(0, 90);
        repeat (lead) send_beat(OP_TICK, CHAR_W'($urandom));
        while (pending || sending)
            send_beat(OP_TICK, CHAR_W'($urandom));
        send_beat(OP_LOAD, ch);
        do
        begin
            if ($urandom_range(0, 31) == 0)
                send_beat(OP_LOAD, CHAR_W'($urandom));
            else
                send_beat(OP_TICK, CHAR_W'($urandom));
        end
        while (pending || sending);
    endtask

    task automatic test_frames();
        play_frame(CHAR_W'($urandom));
    endtask

    // Loosely mixed ticks and loads
    task automatic test_mixed_traffic();
        repeat (400)
        begin
            if ($urandom_range(0, 7) == 0)
                send_beat(OP_LOAD, CHAR_W'($urandom));
            else
                send_beat(OP_TICK, CHAR_W'($urandom));
        end
    endtask

    // Receiver stall pattern: free, light random, heavy random, periodic
    always @(posedge clk)
    begin
        stall_phase++;
        case (stall_phase[9:8])
            2'd0: out_stall <= 1'b0;
            2'd1: out_stall <= ($urandom_range(0, 3) == 0);
            2'd2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= (stall_phase[2:0] < 3'd3);
        endcase
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Result checker: each accepted beat against the oldest expectation
    always @(posedge clk)
    begin
        fsk_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result beat with nothing expected");
                mismatch_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                compare_field("sample_valid", 32'(want.sample_valid), 32'(sample_valid));
                compare_field("dac_code", 32'(want.dac_code), 32'(dac_code));
                compare_field("load_accepted", 32'(want.load_accepted), 32'(load_accepted));
                compare_field("frame_done", 32'(want.frame_done), 32'(frame_done));
                compare_field("busy_res", 32'(want.busy_res), 32'(busy_res));
                results_checked++;
            end
        end
    end

    // Watchdog on cycles with no beat moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("watchdog: no beat accepted for %0d cycles", QUIET_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        reset_modulator_state();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_frames();
        wait_results_drained();
        test_directed();
        wait_results_drained();
        test_mixed_traffic();
        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d beats: %0d loads taken, %0d frames played to the stop bit.",
                 beats_sent, loads_taken, frames_sent);
        $display("Checked %0d result beats, %0d field mismatches.",
                 results_checked, mismatch_count);
        if (mismatch_count == 0 && expected_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[fsk_frame_modulator_top.f]
design/fskm_pkg.sv
design/fskm_wave_rom.sv
design/fskm_frame_ctrl.sv
design/fsk_frame_modulator_top.sv
tb/sv/tb.sv
